>>> hdl/ucs_pkg.sv
// Shared types, character codes and the authority close check for the URL splitter.
package ucs_pkg;

  localparam int MAX_URL_BYTES_DEF = 4096;
  localparam int FIFO_DEPTH_DEF    = 4;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam logic [31:0] HTTP_WORD  = "http";
  localparam logic [39:0] HTTPS_WORD = "https";
  localparam logic [15:0] HTTP_PORT  = 16'd80;
  localparam logic [15:0] HTTPS_PORT = 16'd443;
  localparam logic [16:0] PORT_MAX   = 17'd65535;
  localparam logic [2:0]  PORT_DIGITS_MAX = 3'd5;

  typedef enum logic [2:0] {
    PH_SCHEME, PH_AUTH, PH_PATH, PH_QUERY, PH_FRAG, PH_REJECT
  } phase_t;

  typedef enum logic [3:0] {
    CL_OTHER, CL_COLON, CL_SLASH, CL_QUEST, CL_HASH,
    CL_AT, CL_LBRACK, CL_RBRACK, CL_DIGIT
  } cls_t;

  // Classified byte as it travels through the queue (position rides alongside).
  typedef struct packed {
    cls_t       cls;
    logic [7:0] lc_byte;
    logic       over;
    logic       last;
  } item_head_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] port;
  } fin_t;

  typedef struct packed {
    logic        parse_ok;
    logic [12:0] scheme_length;
    logic [11:0] host_offset;
    logic [12:0] host_length;
    logic [15:0] port_number;
    logic [11:0] path_offset;
    logic [12:0] path_length;
    logic [11:0] query_offset;
    logic [12:0] query_length;
    logic [11:0] fragment_offset;
    logic [12:0] fragment_length;
  } result_t;

  // Authority close: bracket must be closed, explicit port must be sane,
  // otherwise fall back to the scheme default.
  function automatic fin_t fin_check(input logic br_open, input logic br_closed,
                                     input logic pt_started, input logic pt_bad,
                                     input logic [2:0] dcnt, input logic [16:0] acc,
                                     input logic is_http, input logic is_https);
    fin_t f;
    f.ok = 1'b1;
    f.port = '0;
    if (br_open && !br_closed) begin
      f.ok = 1'b0;
    end
    if (pt_started) begin
      if (pt_bad || dcnt == 3'd0 || acc == 17'd0 || acc > PORT_MAX) begin
        f.ok = 1'b0;
      end
      f.port = acc[15:0];
    end else if (is_http) begin
      f.port = HTTP_PORT;
    end else if (is_https) begin
      f.port = HTTPS_PORT;
    end
    return f;
  endfunction

endpackage

>>> hdl/ucs_front.sv
// Input side: byte acceptance, character classification and position counting.
module ucs_front #(
  parameter int MAX_URL_BYTES = ucs_pkg::MAX_URL_BYTES_DEF,
  parameter int PW = $clog2(MAX_URL_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_url_byte,
  input  logic                in_last_byte,
  input  logic                fifo_full,
  output logic                push,
  output ucs_pkg::item_head_t push_head,
  output logic [PW-1:0]       push_pos
);
  import ucs_pkg::*;

  localparam logic [PW-1:0] MAX_POS = PW'(MAX_URL_BYTES);

  logic [PW-1:0] pos_r, pos_nxt;
  cls_t          cls;

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    unique case (in_url_byte)
      CH_COLON:  cls = CL_COLON;
      CH_SLASH:  cls = CL_SLASH;
      CH_QUEST:  cls = CL_QUEST;
      CH_HASH:   cls = CL_HASH;
      CH_AT:     cls = CL_AT;
      CH_LBRACK: cls = CL_LBRACK;
      CH_RBRACK: cls = CL_RBRACK;
      default: begin
        cls = (in_url_byte >= CH_ZERO && in_url_byte <= CH_NINE) ? CL_DIGIT : CL_OTHER;
      end
    endcase
  end

  always_comb begin
    push_head.cls     = cls;
    push_head.lc_byte = (in_url_byte >= CH_UPPER_A && in_url_byte <= CH_UPPER_Z) ?
                        (in_url_byte | CASE_BIT) : in_url_byte;
    push_head.over    = (pos_r == MAX_POS);
    push_head.last    = in_last_byte;
    push_pos          = pos_r;
  end

  // saturating position, back to zero after the last byte of a URL
  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      if (in_last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != MAX_POS) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> hdl/ucs_fifo.sv
// Short word queue between the classifier and the parser.
module ucs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ucs_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_SLOT) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_SLOT) ? '0 : rptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/ucs_back.sv
// Parser: phase machine over classified bytes, span tracking, port check, result register.
module ucs_back #(
  parameter int PW = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  ucs_pkg::item_head_t item_head,
  input  logic [PW-1:0]       item_pos,
  output logic                take,
  output logic                out_valid,
  input  logic                out_ready,
  output ucs_pkg::result_t    out_res
);
  import ucs_pkg::*;

  phase_t        phase_r, phase_nxt;
  logic [1:0]    sep_r, sep_nxt;
  logic [39:0]   head_r, head_nxt;
  logic [PW-1:0] slen_r, slen_nxt;
  logic          ui_r, ui_nxt;
  logic [PW-1:0] hbeg_r, hbeg_nxt, hsize_r, hsize_nxt;
  logic          br_open_r, br_open_nxt, br_closed_r, br_closed_nxt, br_tail_r, br_tail_nxt;
  logic          pt_started_r, pt_started_nxt, pt_bad_r, pt_bad_nxt;
  logic [16:0]   acc_r, acc_nxt, acc_step;
  logic [2:0]    dcnt_r, dcnt_nxt;
  logic [PW-1:0] path_beg_r, path_beg_nxt, path_len_r, path_len_nxt;
  logic [PW-1:0] qry_beg_r, qry_beg_nxt, qry_len_r, qry_len_nxt;
  logic [PW-1:0] frg_beg_r, frg_beg_nxt, frg_len_r, frg_len_nxt;
  logic [15:0]   port_fin_r, port_fin_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_t       res_r, res_nxt;

  logic          active, term, do_port;
  logic          http_cur, https_cur, http_n, https_n, ok_end;
  logic [PW-1:0] pos_inc;
  fin_t          fin_cur, fin_end;
  cls_t          cls;

  assign cls      = item_head.cls;
  assign take     = item_valid && (!item_head.last || !out_valid_r || out_ready);
  assign active   = take && (phase_r != PH_REJECT) && !item_head.over;
  assign term     = (cls == CL_SLASH) || (cls == CL_QUEST) || (cls == CL_HASH);
  assign pos_inc  = item_pos + 1'b1;
  assign acc_step = (acc_r << 3) + (acc_r << 1) + 17'(item_head.lc_byte[3:0]);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign http_cur  = (slen_r == PW'(4)) && (head_r[39:8] == HTTP_WORD);
  assign https_cur = (slen_r == PW'(5)) && (head_r == HTTPS_WORD);
  assign http_n    = (slen_nxt == PW'(4)) && (head_nxt[39:8] == HTTP_WORD);
  assign https_n   = (slen_nxt == PW'(5)) && (head_nxt == HTTPS_WORD);

  // authority state is untouched on a terminator byte, so the registered view serves
  assign fin_cur = fin_check(br_open_r, br_closed_r, pt_started_r, pt_bad_r,
                             dcnt_r, acc_r, http_cur, https_cur);
  assign fin_end = fin_check(br_open_nxt, br_closed_nxt, pt_started_nxt, pt_bad_nxt,
                             dcnt_nxt, acc_nxt, http_n, https_n);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take && phase_r != PH_REJECT) begin
      if (item_head.over) begin
        phase_nxt = PH_REJECT;
      end else begin
        unique case (phase_r)
          PH_SCHEME: begin
            if (cls == CL_SLASH && sep_r == 2'd2) phase_nxt = PH_AUTH;
          end
          PH_AUTH: begin
            if (term) begin
              if (!fin_cur.ok)             phase_nxt = PH_REJECT;
              else if (cls == CL_SLASH)    phase_nxt = PH_PATH;
              else if (cls == CL_QUEST)    phase_nxt = PH_QUERY;
              else                         phase_nxt = PH_FRAG;
            end
          end
          PH_PATH: begin
            if (cls == CL_QUEST)     phase_nxt = PH_QUERY;
            else if (cls == CL_HASH) phase_nxt = PH_FRAG;
          end
          PH_QUERY: begin
            if (cls == CL_HASH) phase_nxt = PH_FRAG;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath updates
  always_comb begin
    sep_nxt        = sep_r;
    head_nxt       = head_r;
    slen_nxt       = slen_r;
    ui_nxt         = ui_r;
    hbeg_nxt       = hbeg_r;
    hsize_nxt      = hsize_r;
    br_open_nxt    = br_open_r;
    br_closed_nxt  = br_closed_r;
    br_tail_nxt    = br_tail_r;
    pt_started_nxt = pt_started_r;
    pt_bad_nxt     = pt_bad_r;
    acc_nxt        = acc_r;
    dcnt_nxt       = dcnt_r;
    path_beg_nxt   = path_beg_r;
    path_len_nxt   = path_len_r;
    qry_beg_nxt    = qry_beg_r;
    qry_len_nxt    = qry_len_r;
    frg_beg_nxt    = frg_beg_r;
    frg_len_nxt    = frg_len_r;
    port_fin_nxt   = port_fin_r;
    do_port        = 1'b0;
    if (active) begin
      unique case (phase_r)
        PH_SCHEME: begin
          for (int i = 0; i < 5; i++) begin
            if (item_pos == PW'(i)) head_nxt[8*(4-i) +: 8] = item_head.lc_byte;
          end
          if (cls == CL_COLON) begin
            sep_nxt = 2'd1;
          end else if (cls == CL_SLASH && sep_r == 2'd1) begin
            sep_nxt = 2'd2;
          end else if (cls == CL_SLASH && sep_r == 2'd2) begin
            slen_nxt       = item_pos - PW'(2);
            hbeg_nxt       = pos_inc;
            hsize_nxt      = '0;
            br_open_nxt    = 1'b0;
            br_closed_nxt  = 1'b0;
            br_tail_nxt    = 1'b0;
            pt_started_nxt = 1'b0;
            pt_bad_nxt     = 1'b0;
            acc_nxt        = '0;
            dcnt_nxt       = '0;
          end else begin
            sep_nxt = 2'd0;
          end
        end
        PH_AUTH: begin
          if (term) begin
            port_fin_nxt = fin_cur.port;
            if (cls == CL_SLASH) begin
              path_beg_nxt = item_pos;
              path_len_nxt = PW'(1);
            end else if (cls == CL_QUEST) begin
              qry_beg_nxt = pos_inc;
              qry_len_nxt = '0;
            end else begin
              frg_beg_nxt = pos_inc;
              frg_len_nxt = '0;
            end
          end else if (cls == CL_AT && !ui_r) begin
            // userinfo: drop everything seen so far in the authority
            ui_nxt         = 1'b1;
            hbeg_nxt       = pos_inc;
            hsize_nxt      = '0;
            br_open_nxt    = 1'b0;
            br_closed_nxt  = 1'b0;
            br_tail_nxt    = 1'b0;
            pt_started_nxt = 1'b0;
            pt_bad_nxt     = 1'b0;
            acc_nxt        = '0;
            dcnt_nxt       = '0;
          end else if (br_open_r) begin
            if (!br_closed_r) begin
              if (cls == CL_RBRACK) br_closed_nxt = 1'b1;
              else                  hsize_nxt = hsize_r + 1'b1;
            end else if (!br_tail_r) begin
              br_tail_nxt = 1'b1;
              if (cls == CL_COLON) pt_started_nxt = 1'b1;
            end else if (pt_started_r) begin
              do_port = 1'b1;
            end
          end else if (item_pos == hbeg_r && cls == CL_LBRACK && hsize_r == '0 &&
                       !pt_started_r) begin
            br_open_nxt = 1'b1;
            hbeg_nxt    = pos_inc;
          end else if (pt_started_r) begin
            do_port = 1'b1;
          end else if (cls == CL_COLON) begin
            pt_started_nxt = 1'b1;
          end else begin
            hsize_nxt = hsize_r + 1'b1;
          end
          if (do_port) begin
            if (dcnt_r >= PORT_DIGITS_MAX || cls != CL_DIGIT) begin
              pt_bad_nxt = 1'b1;
            end else begin
              acc_nxt  = acc_step;
              dcnt_nxt = dcnt_r + 1'b1;
            end
          end
        end
        PH_PATH: begin
          if (cls == CL_QUEST) begin
            qry_beg_nxt = pos_inc;
            qry_len_nxt = '0;
          end else if (cls == CL_HASH) begin
            frg_beg_nxt = pos_inc;
            frg_len_nxt = '0;
          end else begin
            path_len_nxt = path_len_r + 1'b1;
          end
        end
        PH_QUERY: begin
          if (cls == CL_HASH) begin
            frg_beg_nxt = pos_inc;
            frg_len_nxt = '0;
          end else begin
            qry_len_nxt = qry_len_r + 1'b1;
          end
        end
        PH_FRAG: begin
          frg_len_nxt = frg_len_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result word and output register control
  always_comb begin
    ok_end = !(phase_nxt == PH_REJECT || phase_nxt == PH_SCHEME ||
               (phase_nxt == PH_AUTH && !fin_end.ok));
    res_nxt = '0;
    if (ok_end) begin
      res_nxt.parse_ok        = 1'b1;
      res_nxt.scheme_length   = 13'(slen_nxt);
      res_nxt.host_offset     = (hsize_nxt != '0) ? 12'(hbeg_nxt) : 12'd0;
      res_nxt.host_length     = 13'(hsize_nxt);
      res_nxt.port_number     = (phase_nxt == PH_AUTH) ? fin_end.port : port_fin_nxt;
      res_nxt.path_offset     = (path_len_nxt != '0) ? 12'(path_beg_nxt) : 12'd0;
      res_nxt.path_length     = 13'(path_len_nxt);
      res_nxt.query_offset    = (qry_len_nxt != '0) ? 12'(qry_beg_nxt) : 12'd0;
      res_nxt.query_length    = 13'(qry_len_nxt);
      res_nxt.fragment_offset = (frg_len_nxt != '0) ? 12'(frg_beg_nxt) : 12'd0;
      res_nxt.fragment_length = 13'(frg_len_nxt);
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (take && item_head.last) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (take && item_head.last) begin
      res_r <= res_nxt;
    end
  end

  // parse state goes back to its cleared form after each URL
  always_ff @(posedge clk) begin
    if (!rst_n || (take && item_head.last)) begin
      phase_r      <= PH_SCHEME;
      sep_r        <= '0;
      head_r       <= '0;
      slen_r       <= '0;
      ui_r         <= 1'b0;
      hbeg_r       <= '0;
      hsize_r      <= '0;
      br_open_r    <= 1'b0;
      br_closed_r  <= 1'b0;
      br_tail_r    <= 1'b0;
      pt_started_r <= 1'b0;
      pt_bad_r     <= 1'b0;
      acc_r        <= '0;
      dcnt_r       <= '0;
      path_beg_r   <= '0;
      path_len_r   <= '0;
      qry_beg_r    <= '0;
      qry_len_r    <= '0;
      frg_beg_r    <= '0;
      frg_len_r    <= '0;
      port_fin_r   <= '0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      sep_r        <= sep_nxt;
      head_r       <= head_nxt;
      slen_r       <= slen_nxt;
      ui_r         <= ui_nxt;
      hbeg_r       <= hbeg_nxt;
      hsize_r      <= hsize_nxt;
      br_open_r    <= br_open_nxt;
      br_closed_r  <= br_closed_nxt;
      br_tail_r    <= br_tail_nxt;
      pt_started_r <= pt_started_nxt;
      pt_bad_r     <= pt_bad_nxt;
      acc_r        <= acc_nxt;
      dcnt_r       <= dcnt_nxt;
      path_beg_r   <= path_beg_nxt;
      path_len_r   <= path_len_nxt;
      qry_beg_r    <= qry_beg_nxt;
      qry_len_r    <= qry_len_nxt;
      frg_beg_r    <= frg_beg_nxt;
      frg_len_r    <= frg_len_nxt;
      port_fin_r   <= port_fin_nxt;
    end
  end

endmodule

>>> hdl/url_component_splitter.sv
// URL component splitter: takes a URL one word (byte) per cycle and, at the word marked
// last_byte, returns one result word with the scheme length, host span, port and the
// path, query and fragment spans, or parse_ok low with all other fields zero. Throughput
// is one byte per cycle while the queue has room: the classifier writes each accepted byte
// into a short queue and the parser drains one queue word per cycle, stalling only on a
// final word while an earlier result waits. A result passes through the queue and then
// the output register onto out_valid, later if earlier words still sit in the queue, and
// waits in that output register; the parser keeps consuming non-final bytes while that
// result waits, and in_ready drops only when the queue is full.
// Offsets count from the first byte of the URL; an empty or absent span reports offset 0
// and length 0. A URL longer than MAX_URL_BYTES bytes fails.
module url_component_splitter #(
  parameter int MAX_URL_BYTES = ucs_pkg::MAX_URL_BYTES_DEF,
  parameter int FIFO_DEPTH    = ucs_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_url_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_parse_ok,
  output logic [12:0] out_scheme_length,
  output logic [11:0] out_host_offset,
  output logic [12:0] out_host_length,
  output logic [15:0] out_port_number,
  output logic [11:0] out_path_offset,
  output logic [12:0] out_path_length,
  output logic [11:0] out_query_offset,
  output logic [12:0] out_query_length,
  output logic [11:0] out_fragment_offset,
  output logic [12:0] out_fragment_length
);
  import ucs_pkg::*;

  // position width: must hold MAX_URL_BYTES itself (saturation point)
  localparam int PW = $clog2(MAX_URL_BYTES + 1);
  localparam int QW = $bits(item_head_t) + PW;

  logic          push, pop, fifo_full, fifo_valid;
  item_head_t    push_head, pop_head;
  logic [PW-1:0] push_pos, pop_pos;
  logic [QW-1:0] push_word, pop_word;
  result_t       res;

  // front: accept and classify
  ucs_front #(
    .MAX_URL_BYTES(MAX_URL_BYTES),
    .PW(PW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_url_byte  (in_url_byte),
    .in_last_byte (in_last_byte),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_head    (push_head),
    .push_pos     (push_pos)
  );

  assign push_word = {push_head, push_pos};

  // decoupling queue
  ucs_fifo #(
    .WIDTH(QW),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_word),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_word),
    .not_empty (fifo_valid)
  );

  assign {pop_head, pop_pos} = pop_word;

  // back: parse, track spans, hold the result
  ucs_back #(
    .PW(PW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (fifo_valid),
    .item_head  (pop_head),
    .item_pos   (pop_pos),
    .take       (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res)
  );

  assign out_parse_ok        = res.parse_ok;
  assign out_scheme_length   = res.scheme_length;
  assign out_host_offset     = res.host_offset;
  assign out_host_length     = res.host_length;
  assign out_port_number     = res.port_number;
  assign out_path_offset     = res.path_offset;
  assign out_path_length     = res.path_length;
  assign out_query_offset    = res.query_offset;
  assign out_query_length    = res.query_length;
  assign out_fragment_offset = res.fragment_offset;
  assign out_fragment_length = res.fragment_length;

  // a failed parse carries nothing but the flag
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_parse_ok |->
      out_scheme_length == 13'd0 && out_host_length == 13'd0 && out_port_number == 16'd0 &&
      out_path_length == 13'd0 && out_query_length == 13'd0 && out_fragment_length == 13'd0)
    else $error("failed parse with nonzero fields");

  // empty spans report offset zero
  a_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_host_length != 13'd0 || out_host_offset == 12'd0) &&
      (out_path_length != 13'd0 || out_path_offset == 12'd0) &&
      (out_query_length != 13'd0 || out_query_offset == 12'd0) &&
      (out_fragment_length != 13'd0 || out_fragment_offset == 12'd0))
    else $error("empty span with nonzero offset");

  // the queue is drained by the parser whenever no result is waiting
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_valid && !out_valid |-> pop)
    else $error("parser stalled with no pending result");

endmodule
